// ===== rtl/lpfr_pkg.sv =====
package lpfr_pkg;

    // Payload buffer depth and the address width that follows from it
    localparam int FRAME_BYTES = 256;
    localparam int FRAME_AW    = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
    localparam logic [16:0] FRAME_BYTES_W = 17'(FRAME_BYTES);

    localparam logic [7:0]  START_MARK    = 8'h3C;
    localparam logic [31:0] TIMEOUT_RESET = 32'd2000;

    // Request codes
    localparam logic [1:0] FUNC_BYTE = 2'd0;
    localparam logic [1:0] FUNC_POLL = 2'd1;
    localparam logic [1:0] FUNC_READ = 2'd2;

    // Parser phases
    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_LEN_LO  = 2'd1;
    localparam logic [1:0] PH_LEN_HI  = 2'd2;
    localparam logic [1:0] PH_PAYLOAD = 2'd3;

    // Event codes
    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_DONE    = 2'd1;
    localparam logic [1:0] EV_DROP    = 2'd2;
    localparam logic [1:0] EV_TIMEOUT = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  rx_byte;
        logic [31:0] now_ms;
        logic [7:0]  read_index;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [15:0] payload_len;
        logic [7:0]  read_data;
        logic        busy_res;
    } t_out_item;

endpackage

// ===== rtl/length_prefixed_frame_receiver.sv =====
// Length-prefixed frame receiver. Each request (byte, timeout poll or buffer
// read) yields exactly one result via the stage 1 and output registers; a new
// request is taken every cycle, limited only by output stall. Frame parsing
// state sits in registers and is updated in the accept cycle; payload bytes go
// to a 256 x 8 synchronous buffer memory written in that same cycle. A read
// request fetches its byte from the buffer port in the accept cycle and the
// data is registered, so a read issued right after the byte it targets sees
// that byte. Reading a buffer entry that no frame has written returns an
// unspecified value. The user writes the timeout register through i_cfg_we
// only while no request is in flight; the block itself does not enforce this.
module length_prefixed_frame_receiver
    import lpfr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic [31:0] i_cfg_data,
    input  logic      i_in_valid,
    input  t_in_item  i_in_item,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_item,
    input  logic      i_out_stall
);

    logic [31:0] r_timeout;
    logic [1:0]  r_phase, n_phase;
    logic [15:0] r_exp_len, n_exp_len;
    logic [15:0] r_rcv_cnt, n_rcv_cnt;
    logic [31:0] r_start, n_start;

    logic [7:0]  r_mem [FRAME_BYTES];
    logic [7:0]  r_rd_data;

    // Stage 1: parser result waiting for buffer read data
    logic        r_s1_valid;
    logic [1:0]  r_s1_event;
    logic [15:0] r_s1_len;
    logic        r_s1_busy;
    logic        r_s1_read;

    // Stage 2: output register
    logic        r_s2_valid;
    t_out_item   r_s2_item;

    logic        s2_free, s1_adv, in_acc;
    logic [1:0]  n_event;
    logic [15:0] n_len;
    logic        mem_we;
    logic [FRAME_AW-1:0] wr_addr, rd_addr;
    logic [15:0] rcv_inc;
    logic [31:0] elapsed;
    logic [15:0] rd_idx_ext;
    logic        rd_in_range;

    // Pipeline flow
    assign s2_free    = !r_s2_valid || !i_out_stall;
    assign s1_adv     = r_s1_valid && s2_free;
    assign o_in_stall = r_s1_valid && !s2_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign o_out_valid = r_s2_valid;
    assign o_out_item  = r_s2_item;

    assign rcv_inc    = r_rcv_cnt + 16'd1;
    assign elapsed    = i_in_item.now_ms - r_start;
    assign wr_addr    = r_rcv_cnt[FRAME_AW-1:0];
    assign rd_idx_ext = 16'(i_in_item.read_index);
    assign rd_addr    = rd_idx_ext[FRAME_AW-1:0];
    assign rd_in_range = 17'(i_in_item.read_index) < FRAME_BYTES_W;

    // Advance the parser for one request
    always_comb begin
        n_phase   = r_phase;
        n_exp_len = r_exp_len;
        n_rcv_cnt = r_rcv_cnt;
        n_start   = r_start;
        n_event   = EV_NONE;
        n_len     = 16'd0;
        mem_we    = 1'b0;
        priority if (i_in_item.func == FUNC_BYTE) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_in_item.rx_byte == START_MARK) begin
                        n_phase = PH_LEN_LO;
                        n_start = i_in_item.now_ms;
                    end
                end
                PH_LEN_LO: begin
                    n_exp_len = 16'(i_in_item.rx_byte);
                    n_phase   = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    n_exp_len = {i_in_item.rx_byte, r_exp_len[7:0]};
                    n_rcv_cnt = 16'd0;
                    if (n_exp_len == 16'd0) begin
                        n_phase = PH_IDLE;
                        n_start = 32'd0;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
                default: begin
                    mem_we    = 17'(r_rcv_cnt) < FRAME_BYTES_W;
                    n_rcv_cnt = rcv_inc;
                    if (rcv_inc >= r_exp_len) begin
                        n_phase   = PH_IDLE;
                        n_exp_len = 16'd0;
                        n_rcv_cnt = 16'd0;
                        n_start   = 32'd0;
                        if (17'(r_exp_len) > FRAME_BYTES_W) begin
                            n_event = EV_DROP;
                        end else begin
                            n_event = EV_DONE;
                            n_len   = r_exp_len;
                        end
                    end
                end
            endcase
        end else if (i_in_item.func == FUNC_POLL) begin
            if (r_phase != PH_IDLE && elapsed >= r_timeout) begin
                n_phase   = PH_IDLE;
                n_exp_len = 16'd0;
                n_rcv_cnt = 16'd0;
                n_start   = 32'd0;
                n_event   = EV_TIMEOUT;
            end
        end else begin
            // Reads and unused codes leave the parser alone
        end
    end

    // Hold timeout register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            r_timeout <= i_cfg_data;
        end
    end

    // Update parser state on accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_exp_len <= 16'd0;
            r_rcv_cnt <= 16'd0;
            r_start   <= 32'd0;
        end else if (in_acc) begin
            r_phase   <= n_phase;
            r_exp_len <= n_exp_len;
            r_rcv_cnt <= n_rcv_cnt;
            r_start   <= n_start;
        end
    end

    // Payload buffer: write stored bytes, fetch read requests
    always_ff @(posedge i_clk) begin
        if (in_acc && mem_we) begin
            r_mem[wr_addr] <= i_in_item.rx_byte;
        end
        if (in_acc && i_in_item.func == FUNC_READ) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Stage 1 payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_event <= n_event;
            r_s1_len   <= n_len;
            r_s1_busy  <= (n_phase != PH_IDLE);
            r_s1_read  <= (i_in_item.func == FUNC_READ) && rd_in_range;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s1_adv) begin
            r_s2_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s2_item.event_res   <= r_s1_event;
            r_s2_item.payload_len <= r_s1_len;
            r_s2_item.read_data   <= r_s1_read ? r_rd_data : 8'd0;
            r_s2_item.busy_res    <= r_s1_busy;
        end
    end

    // Checks
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_s2_valid))
        else $error("input stalled with a free pipeline slot");

    a_payload_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_exp_len != 16'd0 && r_rcv_cnt < r_exp_len))
        else $error("payload phase with invalid length or count");

    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_rcv_cnt == 16'd0 && r_start == 32'd0))
        else $error("idle parser holds stale frame state");

    a_done_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_event != EV_DONE) |-> (r_s1_len == 16'd0))
        else $error("frame length reported without completion");

endmodule
